// File: hdl/three_by_three_kernel_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 kernel filter
// Shared concurrent assertion forms, clocked on rising edges and held off in
// reset.
// ----------------------------------------------------------------------------
`ifndef THREE_BY_THREE_KERNEL_FILTER_MACROS_SVH
`define THREE_BY_THREE_KERNEL_FILTER_MACROS_SVH

// Condition holds on every edge out of reset.
`define TKF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

// Antecedent implies consequent on the same edge.
`define TKF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent on the next edge.
`define TKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tkf_pkg.sv
// ----------------------------------------------------------------------------
// tkf_pkg
// Types and constants shared by the 3x3 kernel filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tkf_pkg;

	localparam int FILT_BITS        = 22;
	localparam int ROW_BITS         = 12;
	localparam int MODE_BITS        = 5;
	localparam int WIDTH_FIELD_BITS = 11;
	localparam int HEIGHT_FIELD_BITS = 13;
	localparam int HEIGHT_LIMIT     = 4096;
	localparam int RESET_WIDTH      = 1024;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 13;
	localparam int QUEUE_DEPTH      = 4;
	localparam int OUT_DEPTH        = 2;
	localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd2;

	// Kernel modes
	localparam logic [MODE_BITS-1:0] MODE_X1      = 5'd0;
	localparam logic [MODE_BITS-1:0] MODE_X2      = 5'd1;
	localparam logic [MODE_BITS-1:0] MODE_X3      = 5'd2;
	localparam logic [MODE_BITS-1:0] MODE_H_FIRST = 5'd3;
	localparam logic [MODE_BITS-1:0] MODE_H_LAST  = 5'd10;
	localparam logic [MODE_BITS-1:0] MODE_V_FIRST = 5'd11;
	localparam logic [MODE_BITS-1:0] MODE_V_LAST  = 5'd18;
	localparam logic [MODE_BITS-1:0] MODE_L_FIRST = 5'd19;
	localparam logic [MODE_BITS-1:0] MODE_L_LAST  = 5'd24;
	localparam logic [MODE_BITS-1:0] MODE_R_FIRST = 5'd25;
	localparam logic [MODE_BITS-1:0] MODE_R_LAST  = 5'd30;

	// Formula within a directional family; c center, a minus side, b plus side
	typedef enum logic [2:0] {
		FAM_AVG_CB,
		FAM_DIFF_CB,
		FAM_SMOOTH,
		FAM_SECOND,
		FAM_DIFF_AB,
		FAM_AVG_AB,
		FAM_SHIFT_A,
		FAM_SHIFT_B
	} fam_t;

	typedef struct packed {
		logic                      valid;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// File: hdl/tkf_queue.sv
// ----------------------------------------------------------------------------
// tkf_queue
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_by_three_kernel_filter_macros.svh"

module tkf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [WIDTH-1:0]             wdata,
	output logic                              full,
	input  wire logic                         pop,
	output logic [WIDTH-1:0]                  rdata,
	output logic                              empty,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign count   = count_q;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	`TKF_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_BITS'(DEPTH), "queue overfilled")
	`TKF_ASSERT_NEXT(a_pop_drains, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - CNT_BITS'(1), "pop without push did not drain one entry")

endmodule

`default_nettype wire

// File: hdl/tkf_front.sv
// ----------------------------------------------------------------------------
// tkf_front
// Accepts pixels, tracks row and column, runs the line store and the 3x3
// window, and queues one window per interior center.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_by_three_kernel_filter_macros.svh"

module tkf_front import tkf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cfg_wr_t                       cfg,
	input  wire logic                          push,
	input  wire logic [PIXEL_BITS-1:0]         pixel,
	output logic                               full,
	input  wire logic [QCNT_BITS-1:0]          mid_count,
	output logic                               mid_push,
	output logic [9*PIXEL_BITS:0]              mid_data,
	output logic [MODE_BITS-1:0]               mode
);

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int RESET_LAST_COL = ((MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

	logic [MODE_BITS-1:0]    mode_q;
	logic [COL_BITS-1:0]     last_col_q;
	logic [ROW_BITS-1:0]     last_row_q;
	logic [COL_BITS-1:0]     col_q;
	logic [ROW_BITS-1:0]     row_q;

	logic                    accept;
	logic [COL_BITS-1:0]     cfg_last_col;
	logic [ROW_BITS-1:0]     cfg_last_row;
	logic [WIDTH_FIELD_BITS-1:0]  width_val;
	logic [HEIGHT_FIELD_BITS-1:0] height_val;

	logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] line_rd_s1;
	logic                    valid_s1;
	logic                    produce_s1;
	logic                    end_s1;
	logic [PIXEL_BITS-1:0]   px_s1;
	logic [COL_BITS-1:0]     col_s1;

	logic [PIXEL_BITS-1:0]   window_q [3][3];
	logic [PIXEL_BITS-1:0]   win_next [3][3];
	logic [8:0][PIXEL_BITS-1:0] win_flat;

	assign accept = push && !full;
	assign full   = (32'(mid_count) + 32'(valid_s1)) >= QUEUE_DEPTH;
	assign mode   = mode_q;

	// Clamp requested sizes and keep them as last index
	assign width_val  = cfg.data[WIDTH_FIELD_BITS-1:0];
	assign height_val = cfg.data[HEIGHT_FIELD_BITS-1:0];

	always_comb begin
		if (width_val < WIDTH_FIELD_BITS'(3)) begin
			cfg_last_col = COL_BITS'(2);
		end else if (32'(width_val) > MAX_WIDTH) begin
			cfg_last_col = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			cfg_last_col = COL_BITS'(width_val - 1'b1);
		end
		if (height_val < HEIGHT_FIELD_BITS'(3)) begin
			cfg_last_row = ROW_BITS'(2);
		end else if (32'(height_val) > HEIGHT_LIMIT) begin
			cfg_last_row = ROW_BITS'(HEIGHT_LIMIT - 1);
		end else begin
			cfg_last_row = ROW_BITS'(height_val - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_X1;
			last_col_q <= COL_BITS'(RESET_LAST_COL);
			last_row_q <= ROW_BITS'(HEIGHT_LIMIT - 1);
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			produce_s1 <= 1'b0;
			end_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				produce_s1 <= (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
				end_s1     <= (row_q >= last_row_q) && (col_q >= last_col_q);
				if (col_q >= last_col_q) begin
					col_q <= '0;
					row_q <= (row_q >= last_row_q) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cfg.valid) begin
				case (cfg.index)
					REG_MODE: begin
						mode_q <= cfg.data[MODE_BITS-1:0];
					end
					REG_WIDTH: begin
						last_col_q <= cfg_last_col;
						col_q      <= '0;
						row_q      <= '0;
					end
					REG_HEIGHT: begin
						last_row_q <= cfg_last_row;
						col_q      <= '0;
						row_q      <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Line store: upper line in the high half, middle line in the low half
	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_s1 <= line_mem[col_q];
			px_s1      <= pixel;
			col_s1     <= col_q;
		end
		if (valid_s1) begin
			line_mem[col_s1] <= {line_rd_s1[PIXEL_BITS-1:0], px_s1};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r][0] = window_q[r][1];
			win_next[r][1] = window_q[r][2];
		end
		win_next[0][2] = line_rd_s1[2*PIXEL_BITS-1:PIXEL_BITS];
		win_next[1][2] = line_rd_s1[PIXEL_BITS-1:0];
		win_next[2][2] = px_s1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				win_flat[r*3+c] = win_next[r][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					window_q[r][c] <= '0;
				end
			end
		end else if (valid_s1) begin
			window_q <= win_next;
		end
	end

	assign mid_push = valid_s1 && produce_s1;
	assign mid_data = {end_s1, win_flat};

	`TKF_ASSERT_IMPLY(a_line_port_clash, clk, arst_n, valid_s1, col_s1 != col_q, "line store write collides with next read")

endmodule

`default_nettype wire

// File: hdl/tkf_back.sv
// ----------------------------------------------------------------------------
// tkf_back
// Applies the selected kernel to queued windows and buffers the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_back import tkf_pkg::*; #(
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [MODE_BITS-1:0]    mode,
	input  wire logic                    mid_empty,
	input  wire logic [9*PIXEL_BITS:0]   mid_data,
	output logic                         mid_pop,
	input  wire logic                    pop,
	output logic                         empty,
	output logic signed [FILT_BITS-1:0]  filtered,
	output logic                         frame_end
);

	localparam int ACC_BITS = PIXEL_BITS + 5;

	typedef logic signed [ACC_BITS-1:0] acc_t;

	logic [8:0][PIXEL_BITS-1:0] win;
	acc_t pc, pn, ps, pw, pe, pnw, pne, psw, pse;
	acc_t fa, fb, acc;
	logic              use_fam;
	logic [MODE_BITS-1:0] off;
	fam_t              fam;
	logic              out_full;
	logic [FILT_BITS:0] out_rdata;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	assign win = mid_data[9*PIXEL_BITS-1:0];
	assign pnw = acc_t'($signed(win[0]));
	assign pn  = acc_t'($signed(win[1]));
	assign pne = acc_t'($signed(win[2]));
	assign pw  = acc_t'($signed(win[3]));
	assign pc  = acc_t'($signed(win[4]));
	assign pe  = acc_t'($signed(win[5]));
	assign psw = acc_t'($signed(win[6]));
	assign ps  = acc_t'($signed(win[7]));
	assign pse = acc_t'($signed(win[8]));

	always_comb begin
		fa      = '0;
		fb      = '0;
		off     = '0;
		use_fam = 1'b0;
		acc     = '0;
		case (mode) inside
			MODE_X1: begin
				acc = (pe + pn - pw - ps) <<< 2;
			end
			MODE_X2: begin
				acc = (pn + pw - pe - ps) <<< 2;
			end
			MODE_X3: begin
				acc = (pc <<< 2) + ((pn + ps + pw + pe) <<< 1) + pnw + pne + psw + pse;
			end
			[MODE_H_FIRST:MODE_H_LAST]: begin
				use_fam = 1'b1;
				fa      = pw;
				fb      = pe;
				off     = mode - MODE_H_FIRST;
			end
			[MODE_V_FIRST:MODE_V_LAST]: begin
				use_fam = 1'b1;
				fa      = pn;
				fb      = ps;
				off     = mode - MODE_V_FIRST;
			end
			[MODE_L_FIRST:MODE_L_LAST]: begin
				use_fam = 1'b1;
				fa      = pnw;
				fb      = pse;
				off     = mode - MODE_L_FIRST;
			end
			[MODE_R_FIRST:MODE_R_LAST]: begin
				use_fam = 1'b1;
				fa      = psw;
				fb      = pne;
				off     = mode - MODE_R_FIRST;
			end
			default: begin
				acc = '0;
			end
		endcase
		fam = fam_t'(off[2:0]);
		if (use_fam) begin
			case (fam)
				FAM_AVG_CB:  acc = (pc + fb) <<< 1;
				FAM_DIFF_CB: acc = (pc - fb) <<< 2;
				FAM_SMOOTH:  acc = (pc <<< 1) + fa + fb;
				FAM_SECOND:  acc = ((pc <<< 1) - fa - fb) <<< 2;
				FAM_DIFF_AB: acc = (fa - fb) <<< 2;
				FAM_AVG_AB:  acc = (fa + fb) <<< 1;
				FAM_SHIFT_A: acc = fa <<< 2;
				FAM_SHIFT_B: acc = fb <<< 2;
				default:     acc = '0;
			endcase
		end
	end

	// Advance a window whenever the result buffer has room
	assign mid_pop = !mid_empty && !out_full;

	tkf_queue #(
		.WIDTH(FILT_BITS + 1),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_pop),
		.wdata ({mid_data[9*PIXEL_BITS], FILT_BITS'(acc)}),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty),
		.count (out_count)
	);

	assign filtered  = out_rdata[FILT_BITS-1:0];
	assign frame_end = out_rdata[FILT_BITS] && (out_count != '0);

endmodule

`default_nettype wire

// File: hdl/three_by_three_kernel_filter.sv
// Path: an accepted pixel is registered into the front's stage-one registers;
// its window enters the window queue, then its result the result queue (empty low).
// Throughput: one pixel per clock while full is low; the line store is read at the
// accept edge and written back in the cycle after, and the kernel is combinational.
// Reset (arst_n low, asynchronous): counters, window, queues and config go to
// reset values; line stores are not cleared and have no clearing pass.
// ----------------------------------------------------------------------------
// three_by_three_kernel_filter
// Streaming 3x3 kernel filter over a bordered raster frame. The front part
// classifies each pixel and builds windows, the back part applies the kernel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_by_three_kernel_filter_macros.svh"

module three_by_three_kernel_filter import tkf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// pixel stream in
	input  wire logic                      push,
	input  wire logic [PIXEL_BITS-1:0]     pixel,
	output logic                           full,
	// result stream out
	input  wire logic                      pop,
	output logic                           empty,
	output logic signed [FILT_BITS-1:0]    filtered,
	output logic                           frame_end,
	// register writes
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_wr_t                cfg;
	logic [MODE_BITS-1:0]   mode;
	logic                   mid_push;
	logic [9*PIXEL_BITS:0]  mid_wdata;
	logic [9*PIXEL_BITS:0]  mid_rdata;
	logic                   mid_full;
	logic                   mid_empty;
	logic                   mid_pop;
	logic [QCNT_BITS-1:0]   mid_count;

	// Registers take a write on any cycle; a write to a size restarts the frame
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Front: counters, line store, window and interior classification
	tkf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.pixel    (pixel),
		.full     (full),
		.mid_count(mid_count),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mode     (mode)
	);

	// Window queue decouples the front from kernel back-pressure; the front
	// reserves a slot for every pixel in flight, so a push never meets a full queue
	tkf_queue #(
		.WIDTH(9 * PIXEL_BITS + 1),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty),
		.count (mid_count)
	);

	// Back: kernel evaluation and result buffer
	tkf_back #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode),
		.mid_empty(mid_empty),
		.mid_data (mid_rdata),
		.mid_pop  (mid_pop),
		.pop      (pop),
		.empty    (empty),
		.filtered (filtered),
		.frame_end(frame_end)
	);

	`TKF_ASSERT_IMPLY(a_mid_no_drop, clk, arst_n, mid_push, !mid_full, "window dropped at full queue")

endmodule

`default_nettype wire

// File: sim/three_by_three_kernel_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_by_three_kernel_filter_tb
// Self-checking bench for the 3x3 kernel filter. Pixels go in through the
// push/full queue port and filtered values come back through empty/pop. A
// behavioral copy of the line stores, window and counters predicts every
// result, including the frame_end flag. A short directed table with a few
// hand-computed values runs first. It is followed by a fragment at the widest
// line, a whole 64-wide frame, a tall narrow frame that steps through every
// mode code, and random phases with random sizes, modes, stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------

module three_by_three_kernel_filter_tb;
	import tkf_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int PIX_BITS      = 16;
	localparam int STALL_LIMIT   = 5000;  // cycles with no transaction of any kind
	localparam int HOLD_CYCLES   = 300;   // long output hold-off
	localparam int DRAIN_CYCLES  = 8;     // settling margin after the last owed result
	localparam int WIDE_FRAGMENT = 64;    // pixels sent at the widest line
	localparam int WIDE_W        = 64;    // width of the whole wide frame
	localparam int RANDOM_PIXELS = 240;

	// Mode code with no kernel behind it, and the register index that maps to nothing
	localparam logic [MODE_BITS-1:0]      MODE_UNUSED = 5'd31;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE   = 2'd3;

	typedef struct packed {
		logic signed [FILT_BITS-1:0] value;
		logic                        last;
	} result_t;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
		logic signed [PIX_BITS-1:0] px;
		bit                        typed;
		result_t                   res;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic [PIX_BITS-1:0]         pixel;
	logic                        full;
	logic                        pop;
	logic                        empty;
	logic signed [FILT_BITS-1:0] filtered;
	logic                        frame_end;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;

	three_by_three_kernel_filter #(
		.MAX_WIDTH  (MAX_W),
		.PIXEL_BITS (PIX_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.filtered  (filtered),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Filter predictor: mirror of the registers, line stores, window, counters
	// ------------------------------------------------------------------------
	logic [MODE_BITS-1:0]       kmode;
	int unsigned                line_w;
	int unsigned                frame_h;
	int unsigned                col;
	int unsigned                row;
	logic signed [PIX_BITS-1:0] upper_mem  [MAX_W];
	logic signed [PIX_BITS-1:0] middle_mem [MAX_W];
	logic signed [PIX_BITS-1:0] win [3][3];

	result_t   filtered_q[$];   // filtered values still owed by the block
	stim_row_t directed_rows[$];
	result_t   head;

	// Run bookkeeping
	int          mismatches;
	int          quiet_cycles;
	int          pixels_sent;
	int          rand_pixels;
	int          results_seen;
	int          writes_done;
	int          holds_done;
	int          phases;
	logic [31:0] modes_seen;
	bit          burst;     // no idling on either side while set
	bit          hold_req;  // ask the output side for one long hold-off

	// One formula shared by the four directional families: c center, a the
	// minus-side neighbor, b the plus-side neighbor. All values are times four.
	function automatic longint directional(input fam_t f, input longint c,
			input longint a, input longint b);
		case (f)
			FAM_AVG_CB:  return 2 * (c + b);
			FAM_DIFF_CB: return 4 * (c - b);
			FAM_SMOOTH:  return 2 * c + a + b;
			FAM_SECOND:  return 4 * (2 * c - a - b);
			FAM_DIFF_AB: return 4 * (a - b);
			FAM_AVG_AB:  return 2 * (a + b);
			FAM_SHIFT_A: return 4 * a;
			default:     return 4 * b;
		endcase
	endfunction

	function automatic longint kernel_value();
		longint               c, n, s, w, e, nw, ne, sw, se;
		logic [MODE_BITS-1:0] k;
		c  = win[1][1];
		n  = win[0][1];
		s  = win[2][1];
		w  = win[1][0];
		e  = win[1][2];
		nw = win[0][0];
		se = win[2][2];
		sw = win[2][0];
		ne = win[0][2];
		if (kmode == MODE_X1)
			return 4 * (e + n - w - s);
		if (kmode == MODE_X2)
			return 4 * (-e + n + w - s);
		if (kmode == MODE_X3)
			return 4 * c + 2 * (n + s + w + e) + nw + ne + sw + se;
		if (kmode <= MODE_H_LAST) begin
			k = kmode - MODE_H_FIRST;
			return directional(fam_t'(k[2:0]), c, w, e);
		end
		if (kmode <= MODE_V_LAST) begin
			k = kmode - MODE_V_FIRST;
			return directional(fam_t'(k[2:0]), c, n, s);
		end
		// diagonal families have six members, so no shift entries
		if (kmode <= MODE_L_LAST) begin
			k = kmode - MODE_L_FIRST;
			return directional(fam_t'(k[2:0]), c, nw, se);
		end
		if (kmode <= MODE_R_LAST) begin
			k = kmode - MODE_R_FIRST;
			return directional(fam_t'(k[2:0]), c, sw, ne);
		end
		return 0;
	endfunction

	// Register write as the block sees it; size writes clamp and restart the frame
	function automatic void apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		int unsigned wv;
		int unsigned hv;
		case (idx)
			REG_MODE: kmode = data[MODE_BITS-1:0];
			REG_WIDTH: begin
				wv = data[WIDTH_FIELD_BITS-1:0];
				line_w = (wv < 3) ? 3 : (wv > MAX_W) ? MAX_W : wv;
				col = 0;
				row = 0;
			end
			REG_HEIGHT: begin
				hv = data[HEIGHT_FIELD_BITS-1:0];
				frame_h = (hv < 3) ? 3 : (hv > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hv;
				col = 0;
				row = 0;
			end
			default: ;
		endcase
	endfunction

	// Advance the predictor by one accepted pixel and queue what it owes.
	// A typed row replaces the predicted value with a hand-computed one.
	function automatic void filter_pixel(input logic signed [PIX_BITS-1:0] px,
			input bit typed, input result_t typed_res);
		logic signed [PIX_BITS-1:0] top;
		logic signed [PIX_BITS-1:0] mid;
		longint                     v;
		result_t                    r;
		int                         i;
		top = upper_mem[col];
		mid = middle_mem[col];
		upper_mem[col]  = mid;
		middle_mem[col] = px;
		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		if (row >= 2 && col >= 2) begin
			v = kernel_value();
			r.value = v[FILT_BITS-1:0];
			r.last  = (row + 1 >= frame_h) && (col + 1 >= line_w);
			filtered_q.push_back(typed ? typed_res : r);
			modes_seen[kmode] = 1'b1;
		end
		if (col + 1 >= line_w) begin
			col = 0;
			row = (row + 1 >= frame_h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Random shaping
	// ------------------------------------------------------------------------
	// Mostly short gaps, a few medium, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (burst || $urandom_range(0, 99) < 60)
			return 0;
		return gap_len();
	endfunction

	// Lean on the full-scale codes; the rest is uniform over all 16 bits
	function automatic logic signed [PIX_BITS-1:0] rand_pixel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'sh7FFF;
		if (r < 20)
			return 16'sh8000;
		if (r < 25)
			return '0;
		if (r < 30)
			return '1;
		return PIX_BITS'($urandom);
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_size(input int common_hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CFG_DATA_BITS'($urandom_range(3, common_hi));
		if (r < 85)
			return CFG_DATA_BITS'($urandom_range(common_hi + 1, 40));
		if (r < 93)
			return CFG_DATA_BITS'($urandom_range(0, 2));    // clamps up to 3
		return CFG_DATA_BITS'($urandom);                    // upper bits masked or clamped
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_mode_data();
		if ($urandom_range(0, 4) == 0)
			return CFG_DATA_BITS'($urandom);    // junk above the mode bits
		return CFG_DATA_BITS'($urandom_range(0, 31));
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// Offer one pixel and hold it until the block takes it. Push stays high on
	// return so back-to-back pixels need no extra assignment.
	task automatic send_pixel(input logic signed [PIX_BITS-1:0] px,
			input bit typed = 1'b0, input result_t res = '0);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (full);
		filter_pixel(px, typed, res);
		pixels_sent++;
	endtask

	// One register transaction, then one cycle with valid low
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_write(idx, data);
		writes_done++;
		@(posedge clk);
	endtask

	// Drop push, let every owed result come out, then let the pipeline settle
	// so pixels that owe nothing have also been absorbed
	task automatic wait_idle();
		push <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		stim_row_t s;
		s.kind  = ROW_WRITE;
		s.index = idx;
		s.data  = data;
		s.px    = '0;
		s.typed = 1'b0;
		s.res   = '0;
		directed_rows.push_back(s);
	endfunction

	function automatic void add_pixel(input logic signed [PIX_BITS-1:0] px,
			input bit typed = 1'b0, input logic signed [FILT_BITS-1:0] value = '0,
			input logic last = 1'b0);
		stim_row_t s;
		s.kind      = ROW_PIXEL;
		s.index     = '0;
		s.data      = '0;
		s.px        = px;
		s.typed     = typed;
		s.res.value = value;
		s.res.last  = last;
		directed_rows.push_back(s);
	endfunction

	// ------------------------------------------------------------------------
	// Output side: random pop with short and long stalls, one long hold-off
	// on request, counted here so the sender keeps pushing meanwhile
	// ------------------------------------------------------------------------
	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else if (burst || $urandom_range(0, 99) < 70) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker and watchdog; both sample pre-edge values at the edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: filtered %0d, frame_end %0b",
						filtered, frame_end);
					mismatches++;
				end else begin
					head = filtered_q.pop_front();
					if (filtered !== head.value) begin
						$error("filtered: expected %0d, got %0d", head.value, filtered);
						mismatches++;
					end
					if (frame_end !== head.last) begin
						$error("frame_end: expected %0b, got %0b", head.last, frame_end);
						mismatches++;
					end
				end
				results_seen++;
			end
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results owed",
					quiet_cycles, filtered_q.size());
				$display("three_by_three_kernel_filter test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          i;
		int          n;
		int unsigned frame_len;

		clk          = 1'b0;
		arst_n       = 1'b0;
		push         = 1'b0;
		pixel        = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		burst        = 1'b0;
		hold_req     = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		pixels_sent  = 0;
		rand_pixels  = 0;
		results_seen = 0;
		writes_done  = 0;
		holds_done   = 0;
		phases       = 0;
		modes_seen   = '0;

		// Predictor starts from the reset register values
		kmode   = '0;
		line_w  = RESET_WIDTH;
		frame_h = HEIGHT_LIMIT;
		col     = 0;
		row     = 0;
		for (i = 0; i < MAX_W; i++) begin
			upper_mem[i]  = '0;
			middle_mem[i] = '0;
		end
		for (i = 0; i < 9; i++)
			win[i / 3][i % 3] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- Directed table: 3-wide, 4-high frames -------------------------
		// Width 0 clamps up to 3. A flat window under the binomial kernel
		// gives sixteen times the pixel.
		add_write(REG_WIDTH, 13'd0);
		add_write(REG_HEIGHT, 13'd4);
		add_write(REG_MODE, 13'(MODE_X3));
		for (i = 0; i < 8; i++)
			add_pixel(16'sh7FFF);
		add_pixel(16'sh7FFF, 1'b1, 22'sd524272, 1'b0);
		// Last row of the frame: the unused mode still answers, with zero,
		// and flags the frame end; the counters then wrap to the next frame.
		add_write(REG_MODE, 13'(MODE_UNUSED));
		add_pixel(16'sd1);
		add_pixel(-16'sd1);
		add_pixel(16'sh7FFF, 1'b1, 22'sd0, 1'b1);
		// Second frame at the negative full scale
		add_write(REG_MODE, 13'(MODE_X3));
		for (i = 0; i < 8; i++)
			add_pixel(16'sh8000);
		add_pixel(16'sh8000, 1'b1, -22'sd524288, 1'b0);
		add_write(REG_MODE, 13'(MODE_X1));
		add_pixel(16'sd12345);
		add_pixel(-16'sd2);
		add_pixel(16'sh7FFF);
		// Spare index is ignored; all-ones height clamps to the limit; a width
		// with only bit 11 set masks to zero and clamps to 3. Both restart.
		add_write(REG_SPARE, 13'h1FFF);
		add_write(REG_HEIGHT, 13'h1FFF);
		add_write(REG_WIDTH, 13'h0800);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_pixel(directed_rows[i].px, directed_rows[i].typed,
					directed_rows[i].res);
			end
		end

		// --- Widest line, then a whole wide frame ---------------------------
		// All-ones width data masks to 2047 and clamps to the store depth; a
		// fragment of the first row runs the column counter through the first
		// WIDE_FRAGMENT columns. The next width write restarts the frame.
		wait_idle();
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'd3);
		write_reg(REG_MODE, rand_mode_data());
		burst = ($urandom_range(0, 1) == 0);
		for (i = 0; i < WIDE_FRAGMENT; i++)
			send_pixel(rand_pixel());
		wait_idle();
		write_reg(REG_WIDTH, 13'(WIDE_W));
		for (i = 0; i < 3 * WIDE_W; i++)
			send_pixel(rand_pixel());

		// --- Tall 3-wide frame at the height limit -------------------------
		// Each row past the second yields one result; step the mode before
		// each one so every code, the unused one too, gets checked.
		wait_idle();
		burst = 1'b0;
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'(HEIGHT_LIMIT));
		for (i = 0; i < 34 * 3; i++) begin
			if (i % 3 == 0 && i >= 6) begin
				wait_idle();
				write_reg(REG_MODE, 13'(i / 3 - 2));
			end
			send_pixel(rand_pixel());
		end

		// --- Random phases ------------------------------------------------
		while (rand_pixels < RANDOM_PIXELS) begin
			wait_idle();
			burst = ($urandom_range(0, 3) == 0);
			if (phases == 1) begin
				// Output held off while the input runs flat out: the block
				// must fill up and push back through full.
				write_reg(REG_WIDTH, 13'd3);
				write_reg(REG_HEIGHT, 13'd8);
				burst    = 1'b1;
				hold_req = 1'b1;
				n        = 72;
			end else begin
				if ($urandom_range(0, 4) != 0)
					write_reg(REG_WIDTH, rand_size(8));
				if ($urandom_range(0, 4) != 0)
					write_reg(REG_HEIGHT, rand_size(8));
				if ($urandom_range(0, 9) == 0)
					write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
				// Mostly whole frames with random content, otherwise a
				// fragment that leaves the frame open for the next phase
				frame_len = line_w * frame_h;
				if ($urandom_range(0, 3) != 0)
					n = frame_len * $urandom_range(1, 2);
				else
					n = $urandom_range(1, 40);
				if (n > 150)
					n = 150;
			end
			write_reg(REG_MODE, rand_mode_data());
			for (i = 0; i < n; i++) begin
				send_pixel(rand_pixel());
				rand_pixels++;
				// Change the kernel between rows now and then
				if (col == 0 && !hold_req && $urandom_range(0, 6) == 0) begin
					wait_idle();
					write_reg(REG_MODE, rand_mode_data());
				end
			end
			phases++;
		end

		// --- Drain and report -------------------------------------------------
		wait_idle();
		$display("run covered %0d pixels, %0d results, %0d register writes, %0d random phases",
			pixels_sent, results_seen, writes_done, phases);
		$display("%0d of 32 mode codes produced results, %0d long output hold-off(s)",
			$countones(modes_seen), holds_done);
		if (mismatches == 0)
			$display("three_by_three_kernel_filter test passed");
		else
			$display("three_by_three_kernel_filter test failed");
		$finish;
	end

endmodule
